FILE: src/sfst_pkg.sv
// Shared constants, types and register codes for the stereo fade and silence trim block.
package sfst_pkg;

  // Field widths
  localparam int CH_W        = 16;
  localparam int CNT_W       = 32;
  localparam int LEN_W       = 24;
  localparam int START_W     = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_DATA_W   = 2 * CH_W;
  localparam int OUT_DATA_W  = 2 * CH_W + CNT_W;

  // Default index counter width
  localparam int INDEX_BITS_DEF = 32;

  // Results one item can cause, and the matching queue pointer width
  localparam int QDEPTH = 3;
  localparam int Q_W    = 2;

  // Levels
  localparam logic [CH_W-1:0]   ZERO_LEVEL  = 16'h8000;
  localparam logic [2*CH_W-1:0] SILENT_PAIR = 32'h8000_8000;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 32'hffff_ffff;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_START  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FADE_LENGTH = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_END     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PAD_BEGIN   = 8'd3;

  // Register reset values
  localparam logic [START_W-1:0] FADE_START_RST  = 32'd0;
  localparam logic [LEN_W-1:0]   FADE_LENGTH_RST = 24'd39690;
  localparam logic [LEN_W-1:0]   PAD_END_RST     = 24'd4410;
  localparam logic [LEN_W-1:0]   PAD_BEGIN_RST   = 24'd4410;

  // Work handed to each fade lane
  typedef struct packed {
    logic [LEN_W-1:0] k;       // position within the fade
    logic [LEN_W-1:0] remain;  // fade length minus position
    logic [LEN_W-1:0] len;     // fade length
  } fade_cmd_t;

  // Resolved pair handed to the merge stage
  typedef struct packed {
    logic [CH_W-1:0] l;
    logic [CH_W-1:0] r;
    logic            keep;
    logic            last;
  } pair_t;

  // One run result
  typedef struct packed {
    logic [CH_W-1:0]  l;
    logic [CH_W-1:0]  r;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } result_t;

endpackage

FILE: src/sfst_lane.sv
// One fade lane: multiply, offset add and a 16-step restoring divide for one channel.
module sfst_lane
  import sfst_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fade_cmd_t       cmd,
  input  logic [CH_W-1:0] sample,
  output logic            done,
  output logic [CH_W-1:0] faded
);

  localparam int PROD_W = CH_W + LEN_W;
  localparam int DVD_W  = PROD_W + 2;
  localparam int REM_W  = LEN_W + 1;
  localparam int STEP_W = $clog2(CH_W);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_ADD  = 2'd2;
  localparam logic [1:0] PH_DIV  = 2'd3;

  logic [1:0]        phase;
  logic [STEP_W-1:0] step;
  logic [CH_W-1:0]   val;
  fade_cmd_t         job;
  logic [PROD_W-1:0] prod;
  logic [REM_W-1:0]  rem;
  logic [CH_W-1:0]   low;
  logic [REM_W-1:0]  dsr;
  logic [CH_W-1:0]   quo;

  logic [DVD_W-1:0]  num;
  logic [DVD_W-1:0]  dvd;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    trial_sub;
  logic              ge;

  // Dividend 2*(v*(L-k) + 0x8000*k) + L, divisor 2*L
  always_comb begin
    num = {{(DVD_W-PROD_W){1'b0}}, prod}
        + ({{(DVD_W-LEN_W){1'b0}}, job.k} << (CH_W - 1));
    dvd = (num << 1) + {{(DVD_W-LEN_W){1'b0}}, job.len};
  end

  // One quotient bit per cycle
  always_comb begin
    trial     = {rem, low[CH_W-1]};
    ge        = trial >= {1'b0, dsr};
    trial_sub = trial - {1'b0, dsr};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) phase <= PH_MUL;
        end
        PH_MUL: phase <= PH_ADD;
        PH_ADD: begin
          phase <= PH_DIV;
          step  <= '0;
        end
        PH_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(CH_W - 1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      val <= sample;
      job <= cmd;
    end
    if (phase == PH_MUL) prod <= PROD_W'(val) * PROD_W'(job.remain);
    if (phase == PH_ADD) begin
      // quotient fits in CH_W bits, so the upper part is already below the divisor
      rem <= dvd[CH_W +: REM_W];
      low <= dvd[CH_W-1:0];
      dsr <= {job.len, 1'b0};
      quo <= '0;
    end
    if (phase == PH_DIV) begin
      rem <= ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
      low <= {low[CH_W-2:0], 1'b0};
      quo <= {quo[CH_W-2:0], ge};
    end
  end

  assign faded = quo;

endmodule

FILE: src/sfst_merge.sv
// Merge stage: silence tracking, pad and run generation, and the result queue.
module sfst_merge
  import sfst_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  output logic             pair_ready,
  input  pair_t            pair,
  input  logic [LEN_W-1:0] pad_begin,
  input  logic [LEN_W-1:0] pad_end,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_res
);

  logic            started;
  logic [CNT_W-1:0] pending;
  result_t         q_ent [QDEPTH];
  logic [Q_W-1:0]  q_count;
  logic [Q_W-1:0]  q_rd;

  logic            silent;
  logic            sound;
  logic            begin_pad;
  logic            inner_run;
  result_t         ent [QDEPTH];
  logic [Q_W-1:0]  n;
  logic            started_next;
  logic [CNT_W-1:0] pending_next;
  logic            take;

  assign take       = pair_valid && pair_ready;
  assign pair_ready = (q_count == '0);

  // Build the results of one pair in order
  always_comb begin
    silent    = ({pair.l, pair.r} == SILENT_PAIR);
    sound     = pair.keep && !silent;
    begin_pad = !started && (sound || pair.last);
    inner_run = sound && started && (pending != '0);
    n         = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      ent[i] = '{l: ZERO_LEVEL, r: ZERO_LEVEL, cnt: '0, last: 1'b0};
    end
    if (begin_pad) begin
      ent[n] = '{l: ZERO_LEVEL, r: ZERO_LEVEL,
                 cnt: {{(CNT_W-LEN_W){1'b0}}, pad_begin}, last: 1'b0};
      n = n + 1'b1;
    end
    if (inner_run) begin
      ent[n] = '{l: ZERO_LEVEL, r: ZERO_LEVEL, cnt: pending, last: 1'b0};
      n = n + 1'b1;
    end
    if (sound) begin
      ent[n] = '{l: pair.l, r: pair.r, cnt: CNT_W'(1), last: 1'b0};
      n = n + 1'b1;
    end
    if (pair.last) begin
      ent[n] = '{l: ZERO_LEVEL, r: ZERO_LEVEL,
                 cnt: {{(CNT_W-LEN_W){1'b0}}, pad_end}, last: 1'b1};
      n = n + 1'b1;
    end
  end

  // Stream state; cleared at the end of every clip
  always_comb begin
    started_next = started;
    pending_next = pending;
    if (pair.last) begin
      started_next = 1'b0;
      pending_next = '0;
    end else if (sound) begin
      started_next = 1'b1;
      pending_next = '0;
    end else if (pair.keep && started && pending != CNT_MAX) begin
      pending_next = pending + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      pending <= '0;
    end else if (take) begin
      started <= started_next;
      pending <= pending_next;
    end
  end

  // Result queue: filled when empty, drained one request at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
      q_rd    <= '0;
    end else if (take) begin
      q_count <= n;
      q_rd    <= '0;
    end else if (out_valid && out_ready) begin
      if (q_rd + 1'b1 == q_count) begin
        q_count <= '0;
        q_rd    <= '0;
      end else begin
        q_rd <= q_rd + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < QDEPTH; i++) q_ent[i] <= ent[i];
    end
  end

  assign out_valid = (q_count != '0);
  assign out_res   = q_ent[q_rd];

endmodule

FILE: src/stereo_fade_and_silence_trim.sv
// Top level: configuration registers, fade window decision, two fade lanes and the merge stage.
//
// Input stream (s_*): one stereo pair per request, left in s_tdata[15:0],
// right in s_tdata[31:16], s_tlast on the final pair of a clip.
// Output stream (m_*): one run per request: left, right, repeat count in
// m_tdata, m_tlast on the end pad that closes the clip.
// Config channel (cfg_*): register index and data, always ready; write only
// while the block is idle. Indexes above 3 are ignored.
// A pair outside the fade window reaches the merge stage the cycle after it
// is taken, and its results are offered from the registered result queue. A
// faded pair goes through both lanes in parallel: a multiply, an add and the
// 16-step divide in each lane, after which the faded pair enters the merge
// stage. The next pair is accepted as soon as the merge stage has taken the
// previous one. The merge stage takes a pair only once every result of the
// pair before it has drained.
// If the receiver stalls, the queue holds its results and the next resolved
// pair waits in the merge stage; s_tready stays low until it moves on.
// Synchronous reset restores the register defaults, clears the sample index,
// the silence state and the result queue.
module stereo_fade_and_silence_trim
  import sfst_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_DATA_W-1:0]   s_tdata,   // left_sample, right_sample
  input  logic                   s_tlast,   // last_in
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata,   // left_out, right_out, repeat_count
  output logic                   m_tlast,   // last_out
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (INDEX_BITS > START_W) ? INDEX_BITS : START_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FADE  = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

  logic [START_W-1:0]    fade_start;
  logic [LEN_W-1:0]      fade_length;
  logic [LEN_W-1:0]      pad_end_length;
  logic [LEN_W-1:0]      pad_begin_length;
  logic [1:0]            state;
  logic [INDEX_BITS-1:0] sample_index;
  pair_t                 pair;

  logic                  accept;
  logic [CMP_W-1:0]      idx_ext;
  logic [CMP_W-1:0]      start_ext;
  logic [CMP_W-1:0]      k_wide;
  logic                  active;
  logic                  in_window;
  logic                  keep_now;
  logic                  fade_now;
  fade_cmd_t             cmd;
  logic                  lane_start;
  logic                  done_l;
  logic                  done_r;
  logic [CH_W-1:0]       faded_l;
  logic [CH_W-1:0]       faded_r;
  logic                  pair_ready;
  result_t               out_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_start       <= FADE_START_RST;
      fade_length      <= FADE_LENGTH_RST;
      pad_end_length   <= PAD_END_RST;
      pad_begin_length <= PAD_BEGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FADE_START:  fade_start       <= cfg_data[START_W-1:0];
        REG_FADE_LENGTH: fade_length      <= cfg_data[LEN_W-1:0];
        REG_PAD_END:     pad_end_length   <= cfg_data[LEN_W-1:0];
        REG_PAD_BEGIN:   pad_begin_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Fade window: fade inside, drop beyond, pass before; a fade start of zero passes every pair
  always_comb begin
    idx_ext    = CMP_W'(sample_index);
    start_ext  = CMP_W'(fade_start);
    k_wide     = idx_ext - start_ext;
    active     = (fade_start != '0) && (idx_ext >= start_ext);
    in_window  = k_wide < CMP_W'(fade_length);
    keep_now   = !active || in_window;
    fade_now   = active && in_window;
    cmd.k      = k_wide[LEN_W-1:0];
    cmd.remain = fade_length - k_wide[LEN_W-1:0];
    cmd.len    = fade_length;
    lane_start = accept && fade_now;
  end

  // Sample index, saturating, cleared after the last pair
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
    end else if (accept) begin
      if (s_tlast) sample_index <= '0;
      else if (sample_index != INDEX_MAX) sample_index <= sample_index + 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) state <= fade_now ? ST_FADE : ST_MERGE;
        end
        ST_FADE: begin
          if (done_l) state <= ST_MERGE;
        end
        ST_MERGE: begin
          if (pair_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Pair register
  always_ff @(posedge clk) begin
    if (accept) begin
      pair.l    <= s_tdata[CH_W-1:0];
      pair.r    <= s_tdata[2*CH_W-1:CH_W];
      pair.keep <= keep_now;
      pair.last <= s_tlast;
    end else if (state == ST_FADE && done_l) begin
      pair.l <= faded_l;
      pair.r <= faded_r;
    end
  end

  sfst_lane u_lane_l (
    .clk    (clk),
    .rst    (rst),
    .start  (lane_start),
    .cmd    (cmd),
    .sample (s_tdata[CH_W-1:0]),
    .done   (done_l),
    .faded  (faded_l)
  );

  sfst_lane u_lane_r (
    .clk    (clk),
    .rst    (rst),
    .start  (lane_start),
    .cmd    (cmd),
    .sample (s_tdata[2*CH_W-1:CH_W]),
    .done   (done_r),
    .faded  (faded_r)
  );

  sfst_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (state == ST_MERGE && !done_r),
    .pair_ready (pair_ready),
    .pair       (pair),
    .pad_begin  (pad_begin_length),
    .pad_end    (pad_end_length),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res)
  );

  assign m_tdata = {out_res.cnt, out_res.r, out_res.l};
  assign m_tlast = out_res.last;

endmodule

FILE: src/sfst_checker.sv
// Port-level checks for the stereo fade and silence trim block, bound to the top level.
module sfst_checker
  import sfst_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Nothing is offered straight after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // The closing run is always a silent pad
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |->
      m_tdata[CH_W-1:0] == ZERO_LEVEL && m_tdata[2*CH_W-1:CH_W] == ZERO_LEVEL)
    else $error("end pad not silent");

  // A sound pair is a single, non-final run
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[CH_W-1:0] != ZERO_LEVEL || m_tdata[2*CH_W-1:CH_W] != ZERO_LEVEL)
      |-> m_tdata[OUT_DATA_W-1:2*CH_W] == CNT_W'(1) && !m_tlast)
    else $error("sound pair with bad count or last flag");

endmodule

bind stereo_fade_and_silence_trim sfst_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
